/* design/uart_command_frame_parser_macros.svh */
// assertion macros for the command frame parser checker
// used by ucfp_checker.sv, expects clk and rst in scope
`ifndef UART_COMMAND_FRAME_PARSER_MACROS_SVH
`define UART_COMMAND_FRAME_PARSER_MACROS_SVH

// checked outside reset only
`define UCFP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define UCFP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ucfp_pkg.sv */
// shared types, character codes and sizes for the command frame parser
// no dependencies
package ucfp_pkg;

  localparam int FRAME_LENGTH = 10;
  localparam int CNT_W = $clog2(FRAME_LENGTH + 1);
  localparam int IDX_W = $clog2(FRAME_LENGTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int REPLY_LENGTH = 43;
  localparam int RIDX_W = $clog2(REPLY_LENGTH);
  localparam int HEAD_LENGTH = 17;
  localparam int HEAD_W = $clog2(HEAD_LENGTH);

  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_J = 8'h4A;
  localparam logic [7:0] CH_Q = 8'h51;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [7:0] CH_M = 8'h4D;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_X = 8'h58;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_1 = 8'h31;
  localparam logic [7:0] CH_2 = 8'h32;
  localparam logic [7:0] CH_3 = 8'h33;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [15:0] TEMP_NEG_BASE = 16'h8000;
  localparam logic [15:0] TEMP_INVALID = 16'hFFFF;

  localparam logic [7:0] REPLY_HEAD [HEAD_LENGTH] = '{
    8'h41, 8'h54, 8'h2B, 8'h43, 8'h49, 8'h50, 8'h53, 8'h45, 8'h4E,
    8'h44, 8'h3D, 8'h30, 8'h2C, 8'h32, 8'h36, 8'h0D, 8'h0A
  };

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_DIV,
    FE_REM,
    FE_HUN,
    FE_SUB,
    FE_TEN,
    FE_ONE
  } fe_state_t;

  typedef struct packed {
    logic            query;
    logic            beep;
    logic [2:0]      led_off;
    logic            relay;
    logic [3:0][7:0] temp;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } q_wr_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_rd_t;

endpackage

/* design/ucfp_front.sv */
// front end: frame collection, command decode, temperature conversion
// depends on ucfp_pkg
module ucfp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           mode,
  input  logic [7:0]     rx_byte,
  input  logic [15:0]    raw_temperature,
  input  logic           q_full,
  output ucfp_pkg::q_wr_t wr
);
  import ucfp_pkg::*;

  fe_state_t state, state_next;

  logic [7:0]       frame [FRAME_LENGTH];
  logic [7:0]       fnext [FRAME_LENGTH];
  logic [CNT_W-1:0] count, count_inc;
  logic [2:0]       led_off_bits, led_next;
  logic             relay_level, relay_next;
  logic [3:0][7:0]  temp_chars, temp_new;

  logic             accept, byte_acc, temp_acc;
  logic             frame_done, hdr_ok, beep_cmd, query_cmd;

  logic [15:0] t, t_conv, neg, m5n, m5p;
  logic [6:0]  q;
  logic [9:0]  r;
  logic [3:0]  h, tens, ones;
  logic [6:0]  s;
  logic [28:0] prod_q;
  logic [15:0] qk, diff;
  logic [10:0] r0;
  logic [15:0] prod_h;
  logic [9:0]  hk, s_full;
  logic [14:0] prod_t;
  logic [6:0]  tk, ones_full;

  // temperature conversion and digit extraction datapath
  always_comb begin
    neg = ~raw_temperature + 16'd1;
    m5n = 16'(neg * 16'd5);
    m5p = 16'(raw_temperature * 16'd5);
    if (raw_temperature == TEMP_INVALID) begin
      t_conv = TEMP_INVALID;
    end else if (raw_temperature > TEMP_NEG_BASE) begin
      t_conv = TEMP_NEG_BASE + {3'b000, m5n[15:3]};
    end else begin
      t_conv = {3'b000, m5p[15:3]};
    end
    prod_q = 29'(t) * 29'd4194;
    qk = 16'(q) * 16'd1000;
    diff = t - qk;
    r0 = diff[10:0];
    prod_h = 16'(r) * 16'd41;
    hk = 10'(h) * 10'd100;
    s_full = r - hk;
    prod_t = 15'(s) * 15'd205;
    tk = 7'(tens) * 7'd10;
    ones_full = s - tk;
    ones = ones_full[3:0];
    temp_new[0] = CH_0 + {4'b0000, h};
    temp_new[1] = CH_0 + {4'b0000, tens};
    temp_new[2] = CH_DOT;
    temp_new[3] = CH_0 + {4'b0000, ones};
  end

  // frame decode on the frame as it stands after this byte
  always_comb begin
    for (int i = 0; i < FRAME_LENGTH; i++) begin
      fnext[i] = (count[IDX_W-1:0] == IDX_W'(i)) ? rx_byte : frame[i];
    end
    count_inc = count + CNT_W'(1);
    frame_done = (fnext[0] == CH_E) && (count_inc == CNT_W'(FRAME_LENGTH));
    hdr_ok = frame_done && fnext[1] == CH_S && fnext[2] == CH_P;
    led_next = led_off_bits;
    if (hdr_ok && fnext[4] == CH_L && fnext[5] == CH_E && fnext[6] == CH_D) begin
      for (int i = 0; i < 3; i++) begin
        if (fnext[7] == CH_1 + 8'(i)) begin
          if (fnext[3] == CH_K) begin
            led_next[i] = 1'b0;
          end else if (fnext[3] == CH_G) begin
            led_next[i] = 1'b1;
          end
        end
      end
    end
    relay_next = relay_level;
    if (hdr_ok && fnext[4] == CH_J && fnext[5] == CH_D && fnext[6] == CH_Q &&
        fnext[7] == CH_1) begin
      if (fnext[3] == CH_K) begin
        relay_next = 1'b1;
      end else if (fnext[3] == CH_G) begin
        relay_next = 1'b0;
      end
    end
    beep_cmd = hdr_ok && fnext[3] == CH_F && fnext[4] == CH_M && fnext[5] == CH_Q &&
               fnext[6] == CH_C && fnext[7] == CH_S;
    query_cmd = hdr_ok && fnext[3] == CH_C && fnext[4] == CH_X && fnext[5] == CH_S &&
                fnext[6] == CH_J;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      FE_IDLE: begin
        if (in_valid && in_ready && mode) begin
          state_next = FE_DIV;
        end
      end
      FE_DIV: state_next = FE_REM;
      FE_REM: state_next = FE_HUN;
      FE_HUN: state_next = FE_SUB;
      FE_SUB: state_next = FE_TEN;
      FE_TEN: state_next = FE_ONE;
      FE_ONE: begin
        if (!q_full) begin
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    wr.push = 1'b0;
    wr.cmd.query = 1'b0;
    wr.cmd.beep = 1'b0;
    wr.cmd.led_off = led_off_bits;
    wr.cmd.relay = relay_level;
    wr.cmd.temp = temp_chars;
    unique case (state)
      FE_IDLE: begin
        in_ready = !q_full;
        wr.push = in_valid && !q_full && !mode;
        wr.cmd.query = query_cmd;
        wr.cmd.beep = beep_cmd;
        wr.cmd.led_off = led_next;
        wr.cmd.relay = relay_next;
      end
      FE_ONE: begin
        wr.push = !q_full;
        wr.cmd.temp = temp_new;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;
  assign byte_acc = accept && !mode;
  assign temp_acc = accept && mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
      count <= '0;
      led_off_bits <= 3'b111;
      relay_level <= 1'b0;
      temp_chars <= '0;
    end else begin
      state <= state_next;
      if (byte_acc) begin
        if (fnext[0] != CH_E || frame_done) begin
          count <= '0;
        end else begin
          count <= count_inc;
        end
        led_off_bits <= led_next;
        relay_level <= relay_next;
      end
      if (state == FE_ONE && !q_full) begin
        temp_chars <= temp_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      frame[count[IDX_W-1:0]] <= rx_byte;
    end
    if (temp_acc) begin
      t <= t_conv;
    end
    if (state == FE_DIV) begin
      q <= prod_q[28:22];
    end
    if (state == FE_REM) begin
      r <= (r0 >= 11'd1000) ? 10'(r0 - 11'd1000) : r0[9:0];
    end
    if (state == FE_HUN) begin
      h <= prod_h[15:12];
    end
    if (state == FE_SUB) begin
      s <= s_full[6:0];
    end
    if (state == FE_TEN) begin
      tens <= prod_t[14:11];
    end
  end

endmodule

/* design/ucfp_queue.sv */
// short command queue between front and back ends
// depends on ucfp_pkg
module ucfp_queue (
  input  logic            clk,
  input  logic            rst,
  input  ucfp_pkg::q_wr_t wr,
  output logic            full,
  output ucfp_pkg::q_rd_t rd,
  input  logic            pop
);
  import ucfp_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] used;
  logic              do_push, do_pop;

  assign full = (used == QCNT_W'(QUEUE_DEPTH));
  assign rd.valid = (used != '0);
  assign rd.cmd = slots[rptr];
  assign do_push = wr.push && !full;
  assign do_pop = pop && rd.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        used <= used + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        used <= used - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wr.cmd;
    end
  end

endmodule

/* design/ucfp_back.sv */
// back end: status result or reply byte sequencer
// depends on ucfp_pkg
module ucfp_back (
  input  logic            clk,
  input  logic            rst,
  input  ucfp_pkg::q_rd_t rd,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      reply_byte,
  output logic            reply_valid,
  output logic            last,
  output logic [2:0]      led_off,
  output logic            relay_on,
  output logic            beep_request
);
  import ucfp_pkg::*;

  cmd_t              cur;
  logic              busy;
  logic [RIDX_W-1:0] idx;
  logic              done;
  logic [7:0]        ch;

  always_comb begin
    ch = 8'h00;
    if (idx < RIDX_W'(HEAD_LENGTH)) begin
      ch = REPLY_HEAD[idx[HEAD_W-1:0]];
    end else begin
      unique case (idx)
        6'd17, 6'd41:               ch = CH_E;
        6'd18, 6'd40:               ch = CH_S;
        6'd19, 6'd39:               ch = CH_P;
        6'd20, 6'd25, 6'd30:        ch = CH_L;
        6'd21, 6'd26, 6'd31:        ch = CH_E;
        6'd22, 6'd27, 6'd32:        ch = CH_D;
        6'd23:                      ch = CH_1;
        6'd28:                      ch = CH_2;
        6'd33:                      ch = CH_3;
        6'd24:                      ch = cur.led_off[0] ? CH_G : CH_K;
        6'd29:                      ch = cur.led_off[1] ? CH_G : CH_K;
        6'd34:                      ch = cur.led_off[2] ? CH_G : CH_K;
        6'd35:                      ch = cur.temp[0];
        6'd36:                      ch = cur.temp[1];
        6'd37:                      ch = cur.temp[2];
        6'd38:                      ch = cur.temp[3];
        6'd42:                      ch = CH_LF;
        default:                    ch = 8'h00;
      endcase
    end
  end

  assign out_valid = busy;
  assign reply_valid = cur.query;
  assign reply_byte = cur.query ? ch : 8'h00;
  assign last = !cur.query || (idx == RIDX_W'(REPLY_LENGTH - 1));
  assign led_off = cur.led_off;
  assign relay_on = cur.relay;
  assign beep_request = cur.beep;
  assign done = busy && out_ready && last;
  assign pop = rd.valid && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
        idx <= '0;
      end else if (done) begin
        busy <= 1'b0;
      end else if (busy && out_ready) begin
        idx <= idx + RIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd.cmd;
    end
  end

endmodule

/* design/uart_command_frame_parser.sv */
// top level of the serial command frame parser
// depends on ucfp_pkg, ucfp_front, ucfp_queue, ucfp_back
//
//  channel | handshake            | fields
//  in      | in_valid / in_ready  | mode, rx_byte, raw_temperature
//  out     | out_valid / out_ready| reply_byte, reply_valid, last, led_off,
//          |                      | relay_on, beep_request
//
// a serial byte transaction is taken back to back while the command queue has room
// after a temperature transaction, in_ready is low in digit extraction states FE_DIV,
// FE_REM, FE_HUN, FE_SUB, FE_TEN, FE_ONE, and longer while the command queue is full
// the back end gives one result per out_ready cycle: 1 for status, 43 per query reply
// a two-entry command queue lets input and output stall independently
// synchronous active-high reset, no clearing pass
module uart_command_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] raw_temperature,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  reply_byte,
  output logic        reply_valid,
  output logic        last,
  output logic [2:0]  led_off,
  output logic        relay_on,
  output logic        beep_request
);
  import ucfp_pkg::*;

  q_wr_t wr;
  q_rd_t rd;
  logic  q_full;
  logic  pop;

  ucfp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .rx_byte         (rx_byte),
    .raw_temperature (raw_temperature),
    .q_full          (q_full),
    .wr              (wr)
  );

  ucfp_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .full (q_full),
    .rd   (rd),
    .pop  (pop)
  );

  ucfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .rd           (rd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .reply_byte   (reply_byte),
    .reply_valid  (reply_valid),
    .last         (last),
    .led_off      (led_off),
    .relay_on     (relay_on),
    .beep_request (beep_request)
  );

endmodule

/* design/ucfp_checker.sv */
// port-level checks on the command frame parser, bound to the top level
// depends on uart_command_frame_parser_macros.svh
`include "uart_command_frame_parser_macros.svh"

module ucfp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        mode,
  input logic [7:0]  rx_byte,
  input logic [15:0] raw_temperature,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  reply_byte,
  input logic        reply_valid,
  input logic        last,
  input logic [2:0]  led_off,
  input logic        relay_on,
  input logic        beep_request
);

  // stalled input transaction holds
  `UCFP_ASSERT(a_in_hold, in_valid && !in_ready |=> in_valid && $stable({mode, rx_byte, raw_temperature}), "stalled input changed")

  // stalled result holds
  `UCFP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({reply_byte, reply_valid, last, led_off, relay_on, beep_request}), "stalled result changed")

  // a status result is always the last of its transaction
  `UCFP_ASSERT(a_status_last, out_valid && !reply_valid |-> last, "status result without last")

  // a reply continues without a gap until its last byte
  `UCFP_ASSERT(a_reply_cont, out_valid && out_ready && reply_valid && !last |=> out_valid && reply_valid, "reply interrupted")

  // nothing is offered straight after reset
  `UCFP_ASSERT_RST(a_reset_idle, rst |=> !out_valid, "result offered after reset")

endmodule

bind uart_command_frame_parser ucfp_checker u_checker (.*);
